// ===== src/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and codes for the bitmap block allocator: request and response
// beats, operation codes, configuration register indexes and the block size.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int unsigned ADDR_W       = 32;
  localparam int unsigned BLK_COUNT_W  = 11;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned CFG_INDEX_W  = 1;

  // data block size in bytes, a power of two
  localparam int unsigned BLOCK_BYTES  = 512;
  localparam int unsigned BLOCK_SHIFT  = $clog2(BLOCK_BYTES);

  // operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_COUNT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_DATA_BASE   = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [ADDR_W-1:0] block_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              full_res;
  } rsp_t;

endpackage

// ===== src/bitmap_block_allocator_core.sv =====
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core
// First-fit data-block allocator over a free bitmap held in one synchronous
// memory of (MAX_BLOCKS+7)/8 bytes (one bit per block, 1 = used). An allocate beat
// reads the bitmap one byte per cycle from byte 0, over the first
// min(block_count/8, MAX_BLOCKS/8) bytes, claims the lowest free bit and
// returns data_base + index * BLOCK_BYTES; with no free block it returns
// address 0 and full_res set. A free beat turns the byte address back into a
// block index by a shift (BLOCK_BYTES is a power of two from the package) and
// toggles that bit, so freeing a free block marks it used; addresses below
// data_base or past the bitmap are ignored.
// An allocate that finds a block runs ST_SCAN, paced by the single read port
// delivering one bitmap byte a cycle, then ST_MUL, ST_ADDR and ST_DONE; one
// that finds nothing goes from ST_SCAN to ST_DONE, and an empty scan window
// goes there from ST_IDLE. A free runs ST_DCHK, ST_FRD and ST_FWR (read, then
// write back of the bitmap byte); an index past the bitmap goes from ST_DCHK
// to ST_DONE and an address below data_base from ST_IDLE. One request is
// worked at a time; a new one is accepted while the previous response still
// waits in the output register. After reset a clearing pass writes zeros to
// all (MAX_BLOCKS+7)/8 bytes before the first request is taken; configuration
// writes are accepted throughout.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_core #(
  parameter int unsigned MAX_BLOCKS  = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  // request channel
  input  logic                                req_valid,
  output logic                                req_ready,
  input  bba_pkg::req_t                       req,
  // response channel
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output bba_pkg::rsp_t                       rsp,
  // configuration write port
  input  logic                                cfg_write,
  input  logic [bba_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bba_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import bba_pkg::*;

  // bitmap geometry
  localparam int unsigned MAP_BYTES  = (MAX_BLOCKS + 7) / 8;
  localparam int unsigned SCAN_LIMIT = MAX_BLOCKS / 8;
  localparam int unsigned AW         = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int unsigned CW         = AW + 1;
  localparam int unsigned IW         = AW + 3;

  localparam logic [AW-1:0]     LAST_BYTE = AW'(MAP_BYTES - 1);
  localparam logic [ADDR_W-1:0] BB32      = ADDR_W'(BLOCK_BYTES);
  localparam logic [ADDR_W-1:0] MAXB32    = ADDR_W'(MAX_BLOCKS);
  localparam logic [ADDR_W-1:0] LIMIT32   = ADDR_W'(SCAN_LIMIT);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_ADDR,
    ST_DCHK,
    ST_FRD,
    ST_FWR,
    ST_DONE
  } state_t;

  state_t state;

  // configuration registers
  logic [BLK_COUNT_W-1:0] block_count;
  logic [ADDR_W-1:0]      data_base;

  // bitmap memory
  logic [7:0]    used_map [MAP_BYTES];
  logic [7:0]    map_rdata;
  logic [AW-1:0] map_raddr;
  logic          map_we;
  logic [AW-1:0] map_waddr;
  logic [7:0]    map_wdata;

  // clearing pass and scan pointers
  logic [AW-1:0] clr_ptr;
  logic [CW-1:0] scan_groups;
  logic [CW-1:0] iss_ptr;
  logic [CW-1:0] chk_ptr;
  logic          chk_valid;

  // allocate datapath
  logic [2:0]        zero_bit;
  logic              byte_has_free;
  logic [IW-1:0]     blk_idx;
  logic [ADDR_W-1:0] prod;

  // free datapath: offset from the base, block index by shift
  logic [ADDR_W-1:0] dividend;
  logic [ADDR_W-1:0] quot;
  logic [AW-1:0]     free_byte;

  // staged result
  logic [ADDR_W-1:0] res_addr;
  logic              res_full;

  // scan window for a new allocate
  logic [ADDR_W-1:0] bc_groups32;
  logic [CW-1:0]     groups_next;

  assign req_ready = (state == ST_IDLE);

  assign bc_groups32 = ADDR_W'(block_count[BLK_COUNT_W-1:3]);
  assign groups_next = (bc_groups32 > LIMIT32) ? CW'(SCAN_LIMIT) : CW'(bc_groups32);

  assign quot      = dividend >> BLOCK_SHIFT;
  assign free_byte = quot[AW+2:3];

  // lowest clear bit of the byte under check
  always_comb begin
    zero_bit = 3'd0;
    for (int b = 7; b >= 0; b--) begin
      if (!map_rdata[b]) begin
        zero_bit = 3'(b);
      end
    end
  end

  assign byte_has_free = (map_rdata != 8'hFF);

  // memory port steering
  always_comb begin
    map_raddr = free_byte;
    map_we    = 1'b0;
    map_waddr = free_byte;
    map_wdata = 8'h00;
    unique case (state)
      ST_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_ptr;
      end
      ST_SCAN: begin
        map_raddr = iss_ptr[AW-1:0];
        map_waddr = chk_ptr[AW-1:0];
        map_wdata = map_rdata | (8'h01 << zero_bit);
        map_we    = chk_valid && byte_has_free;
      end
      ST_FWR: begin
        map_we    = 1'b1;
        map_wdata = map_rdata ^ (8'h01 << quot[2:0]);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      used_map[map_waddr] <= map_wdata;
    end
    map_rdata <= used_map[map_raddr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= BLK_COUNT_W'(1024);
      data_base   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BLOCK_COUNT: block_count <= cfg_data[BLK_COUNT_W-1:0];
        REG_DATA_BASE:   data_base   <= cfg_data[ADDR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_ptr   <= '0;
      rsp_valid <= 1'b0;
      iss_ptr   <= '0;
      chk_ptr   <= '0;
      chk_valid <= 1'b0;
    end else begin
      // response register drains; a new beat in ST_DONE reloads it instead
      if (rsp_valid && rsp_ready && (state != ST_DONE)) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          clr_ptr <= clr_ptr + 1'b1;
          if (clr_ptr == LAST_BYTE) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (req_valid) begin
            if (req.operation == OP_ALLOC) begin
              scan_groups <= groups_next;
              iss_ptr     <= '0;
              chk_ptr     <= '0;
              chk_valid   <= 1'b0;
              if (groups_next == '0) begin
                res_addr <= '0;
                res_full <= 1'b1;
                state    <= ST_DONE;
              end else begin
                state <= ST_SCAN;
              end
            end else begin
              res_addr <= '0;
              res_full <= 1'b0;
              dividend <= req.block_address - data_base;
              // below the base: nothing to toggle
              state    <= (req.block_address < data_base) ? ST_DONE : ST_DCHK;
            end
          end
        end

        ST_SCAN: begin
          if (chk_valid && byte_has_free) begin
            // claim written this cycle through the write port
            blk_idx <= {chk_ptr[AW-1:0], zero_bit};
            state   <= ST_MUL;
          end else if (chk_valid && (chk_ptr == CW'(scan_groups - 1'b1))) begin
            res_addr <= '0;
            res_full <= 1'b1;
            state    <= ST_DONE;
          end else begin
            // read of iss_ptr lands next cycle
            chk_ptr   <= iss_ptr;
            chk_valid <= 1'b1;
            iss_ptr   <= iss_ptr + 1'b1;
          end
        end

        ST_MUL: begin
          prod  <= ADDR_W'(ADDR_W'(blk_idx) * BB32);
          state <= ST_ADDR;
        end

        ST_ADDR: begin
          res_addr <= data_base + prod;
          res_full <= 1'b0;
          state    <= ST_DONE;
        end

        ST_DCHK: begin
          // index past the bitmap is ignored
          state <= (quot < MAXB32) ? ST_FRD : ST_DONE;
        end

        ST_FRD: begin
          state <= ST_FWR;
        end

        ST_FWR: begin
          state <= ST_DONE;
        end

        ST_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid    <= 1'b1;
            rsp.address  <= res_addr;
            rsp.full_res <= res_full;
            state        <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // a full response never carries an address
  a_full_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.full_res) |-> (rsp.address == '0))
    else $error("full response with nonzero address");

  // the bitmap is never written while waiting for a request
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !map_we)
    else $error("bitmap write while idle");

  // the byte under check stays inside the scan window
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (chk_ptr < scan_groups))
    else $error("scan ran past its window");

  // a new request is only taken once the previous result has been staged
  a_accept_then_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted back to back");
`endif

endmodule

// ===== verif/bitmap_block_allocator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core_tb
// Self-checking bench for the first-fit block allocator. A behavioural copy
// of the free bitmap predicts every response beat. Directed tests cover the
// corner cases, then randomised allocate/free mixes run under several
// block_count and data_base settings with bursty requests and a stalling
// response side.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_core_tb;
  import bba_pkg::*;

  localparam int unsigned MAX_BLOCKS   = 1024;
  localparam int unsigned MAP_BYTES    = MAX_BLOCKS / 8;
  localparam int unsigned CLK_HALF     = 6;
  // slowest beat: clearing pass, a full scan, sender gap and receiver stall
  localparam int unsigned STUCK_LIMIT  = 4000;
  // tail after the last response: longer than the deepest scan
  localparam int unsigned TAIL_CYCLES  = MAP_BYTES + 16;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   req_valid = 1'b0;
  logic                   req_ready;
  req_t                   req = '0;
  logic                   rsp_valid;
  logic                   rsp_ready = 1'b0;
  rsp_t                   rsp;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_BLOCK_COUNT;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  bitmap_block_allocator_core #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  // shadow copy of the allocator: bitmap (1 = used) and both registers
  logic [7:0]             shadow_map [MAP_BYTES];
  logic [BLK_COUNT_W-1:0] shadow_count;
  logic [ADDR_W-1:0]      shadow_base;

  rsp_t        rsp_due_q [$];
  int unsigned fail_count = 0;
  int unsigned stuck_cycles = 0;
  int unsigned burst_left = 0;

  // first-fit outcome of one request beat; updates the shadow bitmap
  function automatic rsp_t bitmap_outcome(req_t beat);
    rsp_t        res;
    int unsigned groups;
    int unsigned hit;
    bit          found;
    logic [31:0] blk;
    res   = '0;
    found = 1'b0;
    hit   = 0;
    if (beat.operation == OP_ALLOC) begin
      // only whole bytes are scanned, never past the stored bitmap
      groups = shadow_count / 8;
      if (groups > MAP_BYTES) groups = MAP_BYTES;
      for (int g = 0; g < groups && !found; g++) begin
        for (int b = 0; b < 8 && !found; b++) begin
          if (!shadow_map[g][b]) begin
            shadow_map[g][b] = 1'b1;
            hit   = g * 8 + b;
            found = 1'b1;
          end
        end
      end
      if (found) begin
        res.address = shadow_base + ADDR_W'(hit * BLOCK_BYTES);
      end else begin
        res.full_res = 1'b1;
      end
    end else if (beat.block_address >= shadow_base) begin
      // toggle, so a double free marks the block used again
      blk = (beat.block_address - shadow_base) / BLOCK_BYTES;
      if (blk < MAX_BLOCKS) shadow_map[blk / 8][blk % 8] ^= 1'b1;
    end
    return res;
  endfunction

  // byte address inside block idx, with a random offset into the block
  function automatic logic [ADDR_W-1:0] block_addr(int unsigned idx);
    return shadow_base + ADDR_W'(idx * BLOCK_BYTES) + ADDR_W'($urandom_range(0, BLOCK_BYTES - 1));
  endfunction

  // response side: stall pattern switches between steady, random and sparse
  int unsigned stall_mode = 0;
  int unsigned stall_tick = 0;
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 64 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: begin
        rsp_ready <= 1'b1;
      end
      1: begin
        rsp_ready <= 1'($urandom_range(0, 1));
      end
      default: begin
        rsp_ready <= (stall_tick % 5 == 0);
      end
    endcase
  end

  // response beat check against the oldest prediction
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (rsp_due_q.size() == 0) begin
        $error("unexpected response beat: address %h full_res %b", rsp.address, rsp.full_res);
        fail_count++;
      end else begin
        want = rsp_due_q.pop_front();
        if (rsp.address !== want.address) begin
          $error("address: expected %h, got %h", want.address, rsp.address);
          fail_count++;
        end
        if (rsp.full_res !== want.full_res) begin
          $error("full_res: expected %b, got %b", want.full_res, rsp.full_res);
          fail_count++;
        end
      end
    end
  end

  // watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk);
    $display("watchdog: no beat for %0d cycles", STUCK_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // register write, only while the allocator is idle
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    if (idx == REG_BLOCK_COUNT) begin
      shadow_count = val[BLK_COUNT_W-1:0];
    end else begin
      shadow_base = val;
    end
  endtask

  // hold requests off until every predicted response has come back
  task automatic drain_responses();
    req_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (rsp_due_q.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  // one request beat, paced in bursts with random gaps
  task automatic send_beat(logic op, logic [ADDR_W-1:0] addr);
    int unsigned gap;
    req_t        beat;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    beat.operation     = op;
    beat.block_address = addr;
    req_valid <= 1'b1;
    req       <= beat;
    do @(posedge clk); while (!req_ready);
    rsp_due_q.push_back(bitmap_outcome(beat));
  endtask

  // random mix: mostly allocates and frees of blocks near the searched range
  task automatic run_mix(int unsigned beats, int unsigned free_span, int unsigned pause_every);
    int unsigned pick;
    for (int unsigned n = 0; n < beats; n++) begin
      if (pause_every != 0 && n % pause_every == pause_every - 1) drain_responses();
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_beat(OP_ALLOC, $urandom);
      end else if (pick < 90) begin
        send_beat(OP_FREE, block_addr($urandom_range(0, free_span - 1)));
      end else begin
        send_beat(OP_FREE, $urandom);
      end
    end
  endtask

  // defaults after reset: zero address, misaligned free, double free, limits
  task automatic test_reset_defaults();
    send_beat(OP_ALLOC, '0);
    send_beat(OP_ALLOC, '1);
    send_beat(OP_ALLOC, '0);
    send_beat(OP_FREE, ADDR_W'(BLOCK_BYTES + BLOCK_BYTES - 1));
    send_beat(OP_ALLOC, '0);
    send_beat(OP_FREE, ADDR_W'(7 * BLOCK_BYTES));
    send_beat(OP_ALLOC, '0);
    send_beat(OP_FREE, ADDR_W'(MAX_BLOCKS * BLOCK_BYTES));
    send_beat(OP_FREE, '1);
    send_beat(OP_FREE, ADDR_W'((MAX_BLOCKS - 1) * BLOCK_BYTES));
    drain_responses();
  endtask

  // register extremes: empty count, partial byte, count past storage, top base
  task automatic test_config_extremes();
    write_reg(REG_BLOCK_COUNT, '0);
    send_beat(OP_ALLOC, '0);
    drain_responses();
    write_reg(REG_BLOCK_COUNT, 32'd7);
    send_beat(OP_ALLOC, '0);
    drain_responses();
    write_reg(REG_BLOCK_COUNT, 32'h7FF);
    write_reg(REG_DATA_BASE, 32'hFFFF_FE00);
    send_beat(OP_ALLOC, '0);
    send_beat(OP_FREE, 32'h0000_0100);
    send_beat(OP_FREE, '1);
    send_beat(OP_ALLOC, '0);
    drain_responses();
    write_reg(REG_BLOCK_COUNT, 32'd8);
    write_reg(REG_DATA_BASE, '1);
    repeat (3) send_beat(OP_ALLOC, '0);
    send_beat(OP_FREE, '1);
    send_beat(OP_ALLOC, '0);
    send_beat(OP_FREE, 32'hFFFF_FFFE);
    drain_responses();
  endtask

  // small counts fill up quickly, so the full response comes often
  task automatic test_small_counts();
    for (int r = 0; r < 5; r++) begin
      write_reg(REG_BLOCK_COUNT, $urandom_range(8, 48));
      write_reg(REG_DATA_BASE, $urandom);
      run_mix(70, shadow_count + 12, 0);
      drain_responses();
    end
  endtask

  // whole bitmap searched, including counts beyond the stored blocks
  task automatic test_full_range();
    write_reg(REG_BLOCK_COUNT, MAX_BLOCKS);
    write_reg(REG_DATA_BASE, $urandom & ~32'(BLOCK_BYTES - 1));
    run_mix(120, MAX_BLOCKS, 0);
    drain_responses();
    write_reg(REG_BLOCK_COUNT, 32'h7FF);
    write_reg(REG_DATA_BASE, $urandom);
    run_mix(120, MAX_BLOCKS, 0);
    drain_responses();
  endtask

  // sender stops now and then until nothing is outstanding
  task automatic test_drain_pauses();
    write_reg(REG_BLOCK_COUNT, $urandom_range(16, 64));
    write_reg(REG_DATA_BASE, $urandom);
    run_mix(150, shadow_count + 16, 30);
    drain_responses();
  endtask

  initial begin
    for (int i = 0; i < MAP_BYTES; i++) shadow_map[i] = '0;
    shadow_count = BLK_COUNT_W'(1024);
    shadow_base  = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_config_extremes();
    test_small_counts();
    test_full_range();
    test_drain_pauses();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (rsp_due_q.size() != 0) begin
      $error("%0d response beats never arrived", rsp_due_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== bitmap_block_allocator_core.f =====
src/bba_pkg.sv
src/bitmap_block_allocator_core.sv
verif/bitmap_block_allocator_core_tb.sv
